// ----- src/utf8d_pkg.sv -----
package utf8d_pkg;

   localparam int unsigned CODE_POINT_WIDTH = 21;
   localparam int unsigned BYTE_WIDTH       = 8;
   localparam int unsigned BOM_MODE_WIDTH   = 2;

   localparam logic [BOM_MODE_WIDTH-1:0] BOM_NONE     = 2'd0;
   localparam logic [BOM_MODE_WIDTH-1:0] BOM_FEFF     = 2'd1;
   localparam logic [BOM_MODE_WIDTH-1:0] BOM_FFFE     = 2'd2;
   localparam logic [BOM_MODE_WIDTH-1:0] BOM_RESET    = BOM_FEFF;

   localparam logic [CODE_POINT_WIDTH-1:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [CODE_POINT_WIDTH-1:0] CP_MARK_FEFF   = 21'h00FEFF;
   localparam logic [CODE_POINT_WIDTH-1:0] CP_MARK_FFFE   = 21'h00FFFE;
   localparam logic [CODE_POINT_WIDTH-1:0] CP_ASCII_MAX   = 21'h00007F;
   localparam logic [CODE_POINT_WIDTH-1:0] CP_SURR_LOW    = 21'h00D800;
   localparam logic [CODE_POINT_WIDTH-1:0] CP_SURR_HIGH   = 21'h00DFFF;
   localparam logic [CODE_POINT_WIDTH-1:0] CP_MAX         = 21'h10FFFF;

   typedef struct packed {
      logic [CODE_POINT_WIDTH-1:0] code_point;
      logic                        replaced;
      logic                        is_mark;
      logic                        end_of_string;
      logic                        last;
   } result_type;

endpackage

// ----- src/utf8_to_code_point_decoder.sv -----
// An accepted byte waits in the input register; its results then enter the result buffer.
// Throughput: one byte per cycle while rsp_ready is high; two-result bytes stall the input.
// Rate is set by the two-entry result buffer behind the one-byte input register.
// Reset (synchronous, active high): sequence state cleared, string start set, bom_mode = 1,
// input register and result buffer emptied.
module utf8_to_code_point_decoder (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [utf8d_pkg::BYTE_WIDTH-1:0]            req_code_byte,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [utf8d_pkg::CODE_POINT_WIDTH-1:0]      rsp_code_point,
   output logic                                        rsp_replaced,
   output logic                                        rsp_is_mark,
   output logic                                        rsp_end_of_string,
   output logic                                        rsp_last,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [utf8d_pkg::BOM_MODE_WIDTH-1:0]        csr_bom_mode
);

   logic [utf8d_pkg::BOM_MODE_WIDTH-1:0]   bom_mode_ff;
   logic [utf8d_pkg::BYTE_WIDTH-1:0]       byte_ff;
   logic                                   byte_vld_ff;
   logic [utf8d_pkg::CODE_POINT_WIDTH-1:0] partial_ff, partial_in;
   logic [1:0]                             remaining_ff, remaining_in;
   logic                                   at_start_ff, at_start_in;
   utf8d_pkg::result_type                  slot0_ff, slot1_ff;
   logic [1:0]                             count_ff;

   logic                                   pop;
   logic                                   out_free;
   logic                                   process;
   logic                                   is_cont;
   logic                                   cont_path;
   logic                                   pre_en, main_en;
   utf8d_pkg::result_type                  pre_res, main_res;
   logic [utf8d_pkg::CODE_POINT_WIDTH-1:0] shifted;
   logic                                   bad_value;

   assign csr_ready = 1'b1;
   assign pop       = rsp_valid && rsp_ready;
   assign out_free  = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);
   assign req_ready = !byte_vld_ff || out_free;
   assign process   = byte_vld_ff && out_free;

   assign is_cont   = byte_ff[7:6] == 2'b10;
   assign cont_path = (remaining_ff != 2'd0) && is_cont;
   assign shifted   = {partial_ff[utf8d_pkg::CODE_POINT_WIDTH-7:0], byte_ff[5:0]};
   assign bad_value = (shifted <= utf8d_pkg::CP_ASCII_MAX) ||
                      (shifted >= utf8d_pkg::CP_SURR_LOW && shifted <= utf8d_pkg::CP_SURR_HIGH) ||
                      (shifted > utf8d_pkg::CP_MAX);

   always_comb begin
      pre_en       = 1'b0;
      pre_res      = '0;
      main_en      = 1'b0;
      main_res     = '0;
      partial_in   = partial_ff;
      remaining_in = remaining_ff;
      at_start_in  = 1'b0;

      if (at_start_ff && bom_mode_ff == utf8d_pkg::BOM_FEFF) begin
         pre_en             = 1'b1;
         pre_res.code_point = utf8d_pkg::CP_MARK_FEFF;
         pre_res.is_mark    = 1'b1;
      end else if (at_start_ff && bom_mode_ff == utf8d_pkg::BOM_FFFE) begin
         pre_en             = 1'b1;
         pre_res.code_point = utf8d_pkg::CP_MARK_FFFE;
         pre_res.is_mark    = 1'b1;
      end else if (remaining_ff != 2'd0 && !is_cont) begin
         pre_en             = 1'b1;
         pre_res.code_point = utf8d_pkg::CP_REPLACEMENT;
         pre_res.replaced   = 1'b1;
      end

      if (cont_path) begin
         remaining_in = remaining_ff - 2'd1;
         if (remaining_ff == 2'd1) begin
            main_en    = 1'b1;
            partial_in = '0;
            if (bad_value) begin
               main_res.code_point = utf8d_pkg::CP_REPLACEMENT;
               main_res.replaced   = 1'b1;
            end else begin
               main_res.code_point = shifted;
            end
         end else begin
            partial_in = shifted;
         end
      end else begin
         partial_in   = '0;
         remaining_in = 2'd0;
         if (byte_ff == '0) begin
            main_en                = 1'b1;
            main_res.end_of_string = 1'b1;
            at_start_in            = 1'b1;
         end else if (!byte_ff[7]) begin
            main_en             = 1'b1;
            main_res.code_point = utf8d_pkg::CODE_POINT_WIDTH'(byte_ff);
         end else if (byte_ff[7:5] == 3'b110) begin
            partial_in   = utf8d_pkg::CODE_POINT_WIDTH'(byte_ff[4:0]);
            remaining_in = 2'd1;
         end else if (byte_ff[7:4] == 4'b1110) begin
            partial_in   = utf8d_pkg::CODE_POINT_WIDTH'(byte_ff[3:0]);
            remaining_in = 2'd2;
         end else if (byte_ff[7:3] == 5'b11110) begin
            partial_in   = utf8d_pkg::CODE_POINT_WIDTH'(byte_ff[2:0]);
            remaining_in = 2'd3;
         end else begin
            main_en             = 1'b1;
            main_res.code_point = utf8d_pkg::CP_REPLACEMENT;
            main_res.replaced   = 1'b1;
         end
      end

      pre_res.last  = !main_en;
      main_res.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bom_mode_ff  <= utf8d_pkg::BOM_RESET;
         byte_vld_ff  <= 1'b0;
         partial_ff   <= '0;
         remaining_ff <= 2'd0;
         at_start_ff  <= 1'b1;
         count_ff     <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            bom_mode_ff <= csr_bom_mode;
         end
         if (req_ready) begin
            byte_vld_ff <= req_valid;
         end
         if (process) begin
            partial_ff   <= partial_in;
            remaining_ff <= remaining_in;
            at_start_ff  <= at_start_in;
            count_ff     <= {1'b0, pre_en} + {1'b0, main_en};
         end else if (pop) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_code_byte;
      end
      if (process) begin
         slot0_ff <= pre_en ? pre_res : main_res;
         slot1_ff <= main_res;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_valid         = count_ff != 2'd0;
   assign rsp_code_point    = slot0_ff.code_point;
   assign rsp_replaced      = slot0_ff.replaced;
   assign rsp_is_mark       = slot0_ff.is_mark;
   assign rsp_end_of_string = slot0_ff.end_of_string;
   assign rsp_last          = slot0_ff.last;

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

   localparam logic [utf8d_pkg::BOM_MODE_WIDTH-1:0] BOM_UNUSED = 2'd3;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned BYTES_PER_PHASE = 150;
   localparam int unsigned LONG_STALL = 200;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic [utf8d_pkg::BYTE_WIDTH-1:0]       req_code_byte = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic [utf8d_pkg::CODE_POINT_WIDTH-1:0] rsp_code_point;
   logic                                   rsp_replaced;
   logic                                   rsp_is_mark;
   logic                                   rsp_end_of_string;
   logic                                   rsp_last;
   logic                                   csr_valid = 1'b0;
   logic                                   csr_ready;
   logic [utf8d_pkg::BOM_MODE_WIDTH-1:0]   csr_bom_mode = utf8d_pkg::BOM_NONE;

   logic [utf8d_pkg::BYTE_WIDTH-1:0] pending_bytes [$];
   utf8d_pkg::result_type            expected_points [$];
   logic                             byte_taken = 1'b0;
   int unsigned                      send_idle_pct = 0;
   int unsigned                      recv_idle_pct = 0;
   int unsigned                      stall_cycles = 0;
   int unsigned                      failures = 0;

   logic [utf8d_pkg::CODE_POINT_WIDTH-1:0] partial_point;
   logic [1:0]                             conts_left;
   logic                                   at_start;
   logic [utf8d_pkg::BOM_MODE_WIDTH-1:0]   mark_mode;

   utf8_to_code_point_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_code_byte     (req_code_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_point    (rsp_code_point),
      .rsp_replaced      (rsp_replaced),
      .rsp_is_mark       (rsp_is_mark),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_bom_mode      (csr_bom_mode)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic utf8d_pkg::result_type make_result(
         input logic [utf8d_pkg::CODE_POINT_WIDTH-1:0] cp,
         input logic repl, input logic mark, input logic eos);
      utf8d_pkg::result_type r;
      r.code_point    = cp;
      r.replaced      = repl;
      r.is_mark       = mark;
      r.end_of_string = eos;
      r.last          = 1'b0;
      return r;
   endfunction

   function automatic void decode_byte(input logic [utf8d_pkg::BYTE_WIDTH-1:0] b);
      utf8d_pkg::result_type                  found [$];
      logic [utf8d_pkg::CODE_POINT_WIDTH-1:0] v;
      logic                                   absorbed;
      logic                                   bad;
      absorbed = 1'b0;
      if (at_start) begin
         if (mark_mode == utf8d_pkg::BOM_FEFF) begin
            found.push_back(make_result(utf8d_pkg::CP_MARK_FEFF, 1'b0, 1'b1, 1'b0));
         end else if (mark_mode == utf8d_pkg::BOM_FFFE) begin
            found.push_back(make_result(utf8d_pkg::CP_MARK_FFFE, 1'b0, 1'b1, 1'b0));
         end
         at_start = 1'b0;
      end
      if (conts_left != 0) begin
         if (b[7:6] == 2'b10) begin
            absorbed = 1'b1;
            partial_point = {partial_point[utf8d_pkg::CODE_POINT_WIDTH-7:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left == 0) begin
               v = partial_point;
               bad = (v <= utf8d_pkg::CP_ASCII_MAX) ||
                     (v >= utf8d_pkg::CP_SURR_LOW && v <= utf8d_pkg::CP_SURR_HIGH) ||
                     (v > utf8d_pkg::CP_MAX);
               if (bad) begin
                  found.push_back(make_result(utf8d_pkg::CP_REPLACEMENT, 1'b1, 1'b0, 1'b0));
               end else begin
                  found.push_back(make_result(v, 1'b0, 1'b0, 1'b0));
               end
               partial_point = '0;
            end
         end else begin
            found.push_back(make_result(utf8d_pkg::CP_REPLACEMENT, 1'b1, 1'b0, 1'b0));
            partial_point = '0;
            conts_left = '0;
         end
      end
      if (!absorbed) begin
         if (b == 8'h00) begin
            found.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
            at_start = 1'b1;
         end else if (b[7] == 1'b0) begin
            found.push_back(make_result(utf8d_pkg::CODE_POINT_WIDTH'(b), 1'b0, 1'b0, 1'b0));
         end else if (b[7:5] == 3'b110) begin
            partial_point = utf8d_pkg::CODE_POINT_WIDTH'(b[4:0]);
            conts_left = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            partial_point = utf8d_pkg::CODE_POINT_WIDTH'(b[3:0]);
            conts_left = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            partial_point = utf8d_pkg::CODE_POINT_WIDTH'(b[2:0]);
            conts_left = 2'd3;
         end else begin
            found.push_back(make_result(utf8d_pkg::CP_REPLACEMENT, 1'b1, 1'b0, 1'b0));
         end
      end
      if (found.size() != 0) begin
         found[found.size()-1].last = 1'b1;
      end
      foreach (found[i]) begin
         expected_points.push_back(found[i]);
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      utf8d_pkg::result_type want;
      byte_taken <= req_valid && req_ready;
      if (reset) begin
         partial_point = '0;
         conts_left    = '0;
         at_start      = 1'b1;
         mark_mode     = utf8d_pkg::BOM_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            mark_mode = csr_bom_mode;
         end
         if (req_valid && req_ready) begin
            decode_byte(req_code_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("code_point: none expected, got 0x%0h", rsp_code_point);
               failures++;
            end else begin
               want = expected_points.pop_front();
               check_field("code_point", want.code_point, rsp_code_point);
               check_field("replaced", want.replaced, rsp_replaced);
               check_field("is_mark", want.is_mark, rsp_is_mark);
               check_field("end_of_string", want.end_of_string, rsp_end_of_string);
               check_field("last", want.last, rsp_last);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!req_valid || byte_taken) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_code_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_cycles != 0) begin
         rsp_ready    <= 1'b0;
         stall_cycles <= stall_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic drain();
      while (pending_bytes.size() != 0 || req_valid || expected_points.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bom_mode(input logic [utf8d_pkg::BOM_MODE_WIDTH-1:0] mode);
      @(negedge clock);
      csr_bom_mode <= mode;
      csr_valid    <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [utf8d_pkg::BOM_MODE_WIDTH-1:0] modes [5];
      logic [utf8d_pkg::BYTE_WIDTH-1:0]     lead;
      int unsigned                          count;
      int unsigned                          kind;
      int unsigned                          span;
      int unsigned                          conts;
      modes = '{utf8d_pkg::BOM_FFFE, utf8d_pkg::BOM_NONE, BOM_UNUSED, utf8d_pkg::BOM_FEFF,
                utf8d_pkg::BOM_NONE};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 14;
      recv_idle_pct = 45;
      pending_bytes = '{8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                        8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80,
                        8'hF4, 8'h90, 8'h80, 8'h80, 8'hFF, 8'h80, 8'hE2, 8'h41,
                        8'hC3, 8'h00, 8'h41};
      drain();
      for (int p = 0; p < 5; p++) begin
         write_bom_mode(p == 4 ? utf8d_pkg::BOM_MODE_WIDTH'($urandom_range(2)) : modes[p]);
         @(posedge clock);
         send_idle_pct = (p < 2) ? 14 : (p < 4) ? 45 : 0;
         recv_idle_pct = (p < 2) ? 45 : (p < 4) ? 14 : 0;
         count = 0;
         while (count < BYTES_PER_PHASE) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
               pending_bytes.push_back(utf8d_pkg::BYTE_WIDTH'($urandom_range(8'h7F, 1)));
               count++;
            end else if (kind < 80) begin
               span = (kind < 48) ? 2 : (kind < 64) ? 3 : 4;
               if (span == 2) begin
                  lead = {3'b110, 5'($urandom)};
               end else if (span == 3) begin
                  lead = ($urandom_range(3) == 0) ? 8'hED : {4'b1110, 4'($urandom)};
               end else begin
                  lead = {5'b11110, 3'($urandom)};
               end
               conts = ($urandom_range(9) == 0) ? $urandom_range(span - 2) : span - 1;
               pending_bytes.push_back(lead);
               for (int i = 0; i < conts; i++) begin
                  pending_bytes.push_back({2'b10, 6'($urandom)});
               end
               count += conts + 1;
            end else if (kind < 88) begin
               pending_bytes.push_back(8'h00);
               count++;
            end else begin
               pending_bytes.push_back(utf8d_pkg::BYTE_WIDTH'($urandom_range(255)));
               count++;
            end
         end
         if (p == 1) begin
            stall_cycles = LONG_STALL;
         end
         drain();
      end
      if (failures == 0) begin
         $display("utf8_to_code_point_decoder regression: pass");
      end else begin
         $display("utf8_to_code_point_decoder regression: fail");
      end
      $finish;
   end

   initial begin
      #(8 * 200000);
      $display("utf8_to_code_point_decoder regression: fail");
      $finish;
   end

endmodule

// ----- files.f -----
src/utf8d_pkg.sv
src/utf8_to_code_point_decoder.sv
tb/tb_top.sv
